/* rtl/dem_pkg.sv */
// Shared types, register codes and constants for the direction energy map.
// Used by dem_div, dem_bins and direction_energy_map; depends on nothing.
package dem_pkg;

   localparam int NUM_BINS_DEFAULT = 36;
   localparam int CORDIC_STEPS     = 16;
   localparam int BIN_ADDR_W       = 6;
   localparam int CSR_INDEX_W      = 3;
   localparam int DIV_NUM_W        = 16;
   localparam int DIV_DEN_W        = 8;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEVEL      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_THRESHOLD  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BRIGHTNESS = 3'd4;

   localparam logic [7:0] RST_INCREMENT      = 8'd20;
   localparam logic [7:0] RST_MAX_LEVEL      = 8'd200;
   localparam logic [7:0] RST_DECAY_STEP     = 8'd1;
   localparam logic [7:0] RST_MIN_THRESHOLD  = 8'd16;
   localparam logic [7:0] RST_MAX_BRIGHTNESS = 8'd50;

   // Request modes
   localparam logic MODE_OBSERVE = 1'b0;
   localparam logic MODE_READ    = 1'b1;

   // Binary angles of the exact directions
   localparam logic [31:0] ANGLE_ZERO    = 32'h0000_0000;
   localparam logic [31:0] ANGLE_QUARTER = 32'h4000_0000;
   localparam logic [31:0] ANGLE_HALF    = 32'h8000_0000;
   localparam logic [31:0] ANGLE_3QUART  = 32'hC000_0000;

   typedef struct packed {
      logic              mode;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic [8:0]        energy;
      logic [5:0]        read_bin;
   } req_type;

   typedef struct packed {
      logic [5:0] bin;
      logic [7:0] level;
      logic [7:0] brightness;
   } rsp_type;

   // Access to the bin store: one read and one write per cycle
   typedef struct packed {
      logic                  rd_en;
      logic [BIN_ADDR_W-1:0] rd_addr;
      logic                  wr_en;
      logic [BIN_ADDR_W-1:0] wr_addr;
      logic [7:0]            wr_data;
   } bin_cmd_type;

   // atan(2^-i) in binary angle units (2^32 per turn)
   function automatic logic [31:0] atan_turns(input logic [3:0] idx);
      logic [31:0] a;
      case (idx)
         4'd0:    a = 32'h2000_0000;
         4'd1:    a = 32'h12E4_051E;
         4'd2:    a = 32'h09FB_385B;
         4'd3:    a = 32'h0511_11D4;
         4'd4:    a = 32'h028B_0D43;
         4'd5:    a = 32'h0145_D7E1;
         4'd6:    a = 32'h00A2_F61E;
         4'd7:    a = 32'h0051_7C55;
         4'd8:    a = 32'h0028_BE53;
         4'd9:    a = 32'h0014_5F2F;
         4'd10:   a = 32'h000A_2F98;
         4'd11:   a = 32'h0005_17CC;
         4'd12:   a = 32'h0002_8BE6;
         4'd13:   a = 32'h0001_45F3;
         4'd14:   a = 32'h0000_A2FA;
         default: a = 32'h0000_517D;
      endcase
      return a;
   endfunction

endpackage

/* rtl/dem_div.sv */
// Restoring divider, one quotient bit per cycle, for the brightness scale.
// Depends on dem_pkg for the operand widths.
module dem_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dem_pkg::DIV_NUM_W-1:0]  num,
   input  logic [dem_pkg::DIV_DEN_W-1:0]  den,
   output logic                           done,
   output logic [dem_pkg::DIV_NUM_W-1:0]  quo
);

   localparam int NW  = dem_pkg::DIV_NUM_W;
   localparam int DW  = dem_pkg::DIV_DEN_W;
   localparam int CW  = $clog2(NW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] sh_ff, sh_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic          ge;

   assign trial = {rem_ff, sh_ff[NW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         sh_in   = num;
         den_in  = den;
      end else if (busy_ff) begin
         // shift in one numerator bit, subtract when it fits
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         sh_in  = {sh_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

/* rtl/dem_bins.sv */
// Bin level store: one write and one registered read per cycle, with a
// valid bit per entry so that unwritten bins read as zero after reset.
// Depends on dem_pkg for the access struct.
module dem_bins #(
   parameter int NUM_BINS = dem_pkg::NUM_BINS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dem_pkg::bin_cmd_type cmd,
   output logic [7:0]           rd_data
);

   localparam int BIN_W = $clog2(NUM_BINS);

   logic [7:0]          mem_ff [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [7:0]          rd_q_ff;
   logic                rd_vld_ff;
   logic [BIN_W-1:0]    waddr;
   logic [BIN_W-1:0]    raddr;

   assign waddr = cmd.wr_addr[BIN_W-1:0];
   assign raddr = cmd.rd_addr[BIN_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[waddr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_vld_ff <= valid_ff[raddr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : 8'd0;

endmodule

/* rtl/direction_energy_map.sv */
// Direction energy map top level: sequencer, CORDIC angle unit and csr.
// Depends on dem_pkg, dem_bins and dem_div.
//
// Keeps a leaky energy histogram over NUM_BINS azimuth sectors and takes
// one request at a time. An observation request (mode 0) sweeps the bin
// store once to apply the decay step (one bin per cycle through the
// single store port pair, then the last write-back and a closing step)
// while the shift-add CORDIC unit resolves the source angle alongside
// (exact axes directly, other vectors in 16 iterations); then it maps
// the angle to a sector, reads and updates that bin, and scales the level
// to LED brightness with a restoring divider (16 steps). A read request
// (mode 1) reduces read_bin modulo NUM_BINS by repeated subtraction (at
// most 63 / NUM_BINS subtractions, then a final compare) and then goes
// through the read and the divider. req_ready is high only while the
// sequencer is idle; the response sits in an output register, so the
// next request is taken while a finished response still waits for
// rsp_ready. Bins read as zero after reset with no clearing pass. The csr
// port is always ready; write it only while no request is in flight.
module direction_energy_map #(
   parameter int NUM_BINS = dem_pkg::NUM_BINS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dem_pkg::req_type                    req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dem_pkg::rsp_type                    rsp_payload,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dem_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [7:0]                          csr_data
);

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int CNT_W  = $clog2(NUM_BINS + 2);
   localparam int NB_W   = $clog2(NUM_BINS + 1);
   localparam int STEPS  = dem_pkg::CORDIC_STEPS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam int CW     = 36;   // scaled vector: 17 bits << 16, gain, sign

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MOD    = 4'd1;
   localparam logic [3:0] ST_SWEEP  = 4'd2;
   localparam logic [3:0] ST_SECTOR = 4'd3;
   localparam logic [3:0] ST_READ   = 4'd4;
   localparam logic [3:0] ST_LEVEL  = 4'd5;
   localparam logic [3:0] ST_MUL    = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [7:0] inc_ff, maxl_ff, decay_ff, thr_ff, maxb_ff;
   logic       csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= dem_pkg::RST_INCREMENT;
         maxl_ff  <= dem_pkg::RST_MAX_LEVEL;
         decay_ff <= dem_pkg::RST_DECAY_STEP;
         thr_ff   <= dem_pkg::RST_MIN_THRESHOLD;
         maxb_ff  <= dem_pkg::RST_MAX_BRIGHTNESS;
      end else if (csr_wr) begin
         unique case (csr_index)
            dem_pkg::CSR_INCREMENT:      inc_ff   <= csr_data;
            dem_pkg::CSR_MAX_LEVEL:      maxl_ff  <= csr_data;
            dem_pkg::CSR_DECAY_STEP:     decay_ff <= csr_data;
            dem_pkg::CSR_MIN_THRESHOLD:  thr_ff   <= csr_data;
            dem_pkg::CSR_MAX_BRIGHTNESS: maxb_ff  <= csr_data;
            default: ;   // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer and datapath registers
   // ---------------------------------------------------------------
   logic [3:0]            state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [8:0]            energy_ff, energy_in;
   logic [5:0]            bin_ff, bin_in;        // target bin
   logic [CNT_W-1:0]      cnt_ff, cnt_in;        // decay sweep position
   logic [STEP_W-1:0]     it_ff, it_in;          // CORDIC iteration
   logic signed [CW-1:0]  cx_ff, cx_in;
   logic signed [CW-1:0]  cy_ff, cy_in;
   logic [31:0]           ang_ff, ang_in;
   logic [8:0]            add_ff, add_in;
   logic [7:0]            level_ff, level_in;
   logic [7:0]            bright_ff, bright_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   dem_pkg::rsp_type      rsp_ff, rsp_in;

   logic                  req_acc;
   logic                  out_load;
   dem_pkg::bin_cmd_type  bin_cmd;
   logic [7:0]            rd_data;
   logic                  div_start;
   logic                  div_done;
   logic [15:0]           div_quo;
   logic [15:0]           div_num;

   // request setup for the CORDIC unit
   logic signed [16:0]    x17, y17, xs, ys;
   logic [31:0]           ang_init;
   logic                  exact_dir;

   // CORDIC step
   logic signed [CW-1:0]  dx, dy;
   logic                  y_pos;
   logic [31:0]           atan_val;
   logic                  cordic_done;
   logic                  sweep_done;

   logic [31+NB_W:0]      sect_prod;
   logic [16:0]           add_prod;
   logic [9:0]            sum;
   logic [7:0]            lvl_new;
   logic [7:0]            decayed;
   logic [7:0]            b_sat;

   dem_bins #(
      .NUM_BINS (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .reset   (reset),
      .cmd     (bin_cmd),
      .rd_data (rd_data)
   );

   dem_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (maxl_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Resolve the exact axes up front; otherwise reflect x < 0 through
   // the origin and scale by 2^16 for the iterations.
   always_comb begin
      x17       = {req_payload.src_x[15], req_payload.src_x};
      y17       = {req_payload.src_y[15], req_payload.src_y};
      xs        = x17;
      ys        = y17;
      exact_dir = 1'b1;
      ang_init  = dem_pkg::ANGLE_ZERO;
      if (y17 == 17'sd0) begin
         ang_init = x17[16] ? dem_pkg::ANGLE_HALF : dem_pkg::ANGLE_ZERO;
      end else if (x17 == 17'sd0) begin
         ang_init = y17[16] ? dem_pkg::ANGLE_3QUART : dem_pkg::ANGLE_QUARTER;
      end else begin
         exact_dir = 1'b0;
         if (x17[16]) begin
            xs       = -x17;
            ys       = -y17;
            ang_init = dem_pkg::ANGLE_HALF;
         end
      end
   end

   assign dx          = cy_ff >>> it_ff;
   assign dy          = cx_ff >>> it_ff;
   assign y_pos       = !cy_ff[CW-1] && (cy_ff != '0);
   assign atan_val    = dem_pkg::atan_turns(it_ff[3:0]);
   assign cordic_done = (it_ff == STEP_W'(STEPS));
   assign sweep_done  = (cnt_ff == CNT_W'(NUM_BINS + 1));

   assign sect_prod = {{NB_W{1'b0}}, ang_ff} * (32 + NB_W)'(NUM_BINS);
   assign add_prod  = {9'd0, inc_ff} * {8'd0, energy_ff};
   assign decayed   = (rd_data > decay_ff) ? rd_data - decay_ff : 8'd0;
   assign sum       = {2'b00, rd_data} + {1'b0, add_ff};
   assign lvl_new   = (sum > {2'b00, maxl_ff}) ? maxl_ff : sum[7:0];
   assign div_num   = {8'd0, level_ff} * {8'd0, maxb_ff};
   assign b_sat     = (div_quo[15:8] != 8'd0) ? 8'hFF : div_quo[7:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      energy_in    = energy_ff;
      bin_in       = bin_ff;
      cnt_in       = cnt_ff;
      it_in        = it_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      ang_in       = ang_ff;
      add_in       = add_ff;
      level_in     = level_ff;
      bright_in    = bright_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      bin_cmd      = '0;
      div_start    = 1'b0;

      // the waiting response leaves as soon as it is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in   = req_payload.mode;
               energy_in = req_payload.energy;
               bin_in    = req_payload.read_bin;
               cnt_in    = '0;
               ang_in    = ang_init;
               it_in     = exact_dir ? STEP_W'(STEPS) : '0;
               cx_in     = {{(CW - 33){xs[16]}}, xs, 16'd0};
               cy_in     = {{(CW - 33){ys[16]}}, ys, 16'd0};
               state_in  = (req_payload.mode == dem_pkg::MODE_READ) ? ST_MOD
                                                                    : ST_SWEEP;
            end
         end
         ST_MOD: begin
            // reduce read_bin modulo the bin count
            if ({1'b0, bin_ff} >= 7'(NUM_BINS)) begin
               bin_in = bin_ff - 6'(NUM_BINS);
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SWEEP: begin
            // read bin k while writing back decayed bin k-1
            if (cnt_ff < CNT_W'(NUM_BINS)) begin
               bin_cmd.rd_en   = 1'b1;
               bin_cmd.rd_addr = dem_pkg::BIN_ADDR_W'(cnt_ff[BIN_W-1:0]);
            end
            if ((cnt_ff != '0) && !sweep_done) begin
               bin_cmd.wr_en   = 1'b1;
               bin_cmd.wr_addr = dem_pkg::BIN_ADDR_W'(BIN_W'(cnt_ff - 1'b1));
               bin_cmd.wr_data = decayed;
            end
            if (!sweep_done) begin
               cnt_in = cnt_ff + 1'b1;
            end
            // advance the CORDIC unit in parallel
            if (!cordic_done) begin
               if (y_pos) begin
                  cx_in  = cx_ff + dx;
                  cy_in  = cy_ff - dy;
                  ang_in = ang_ff + atan_val;
               end else begin
                  cx_in  = cx_ff - dx;
                  cy_in  = cy_ff + dy;
                  ang_in = ang_ff - atan_val;
               end
               it_in = it_ff + 1'b1;
            end
            if (sweep_done && cordic_done) begin
               state_in = ST_SECTOR;
            end
         end
         ST_SECTOR: begin
            bin_in   = 6'(sect_prod[32 +: BIN_W]);
            add_in   = add_prod[16:8];
            state_in = ST_READ;
         end
         ST_READ: begin
            bin_cmd.rd_en   = 1'b1;
            bin_cmd.rd_addr = bin_ff;
            state_in        = ST_LEVEL;
         end
         ST_LEVEL: begin
            if (mode_ff == dem_pkg::MODE_OBSERVE) begin
               level_in        = lvl_new;
               bin_cmd.wr_en   = 1'b1;
               bin_cmd.wr_addr = bin_ff;
               bin_cmd.wr_data = lvl_new;
            end else begin
               level_in = rd_data;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               // zero ceiling or below threshold: dark
               if ((maxl_ff == 8'd0) || (b_sat < thr_ff)) begin
                  bright_in = 8'd0;
               end else begin
                  bright_in = b_sat;
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the response register is free
            if (out_load) begin
               rsp_valid_in      = 1'b1;
               rsp_in.bin        = bin_ff;
               rsp_in.level      = level_ff;
               rsp_in.brightness = bright_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         it_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         it_ff        <= it_in;
      end
      mode_ff   <= mode_in;
      energy_ff <= energy_in;
      bin_ff    <= bin_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      ang_ff    <= ang_in;
      add_ff    <= add_in;
      level_ff  <= level_in;
      bright_ff <= bright_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a new response only comes out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   // every reported bin lies inside the map
   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_payload.bin} < 7'(NUM_BINS)))
      else $error("response bin out of range");

   // an observation never leaves a level above the ceiling
   a_level_ceiling: assert property (@(posedge clock) disable iff (reset)
      (out_load && (mode_ff == dem_pkg::MODE_OBSERVE)) |-> (level_ff <= maxl_ff))
      else $error("updated level above max_level");

   // the sweep and the CORDIC unit are both finished before the sector
   a_sector_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECTOR) |-> (sweep_done && cordic_done))
      else $error("sector taken before sweep or angle finished");

endmodule

/* dv/dem_checker.sv */
// Checker for direction_energy_map: watches the request, response and csr channels,
// predicts every response from its own copy of the bin levels and registers.
// Depends on dem_pkg for the payload types, register indexes and reset values.
module dem_checker
   import dem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data,
   output int unsigned            outstanding,
   output int unsigned            mismatches
);

   localparam int NUM_BINS     = NUM_BINS_DEFAULT;
   localparam int REPORT_LIMIT = 40;

   // arctangent of 2^-i, in units of 2^-32 of a full turn
   localparam logic [31:0] ATAN_LUT [CORDIC_STEPS] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
   };

   logic [7:0]  level_map [NUM_BINS];
   logic [7:0]  gain, ceiling, decay, threshold, full_bright;
   rsp_type     expected_rsp [$];
   int unsigned fail_count;

   function automatic logic [31:0] source_angle(input longint sx, input longint sy);
      longint      x, y, dx, dy;
      logic [31:0] ang;
      x   = sx;
      y   = sy;
      ang = ANGLE_ZERO;
      if (y == 0) return (x < 0) ? ANGLE_HALF : ANGLE_ZERO;
      if (x == 0) return (y > 0) ? ANGLE_QUARTER : ANGLE_3QUART;
      if (x < 0) begin
         x   = -x;
         y   = -y;
         ang = ANGLE_HALF;
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x   = x + dx;
            y   = y - dy;
            ang = ang + ATAN_LUT[i];
         end else begin
            x   = x - dx;
            y   = y + dy;
            ang = ang - ATAN_LUT[i];
         end
      end
      return ang;
   endfunction

   // Update the predicted map for one request and return its response.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type     o;
      logic [31:0] ang;
      logic [63:0] prod;
      int unsigned idx, sum, b;
      if (r.mode == MODE_OBSERVE) begin
         for (int i = 0; i < NUM_BINS; i++)
            level_map[i] = (level_map[i] > decay) ? level_map[i] - decay : 8'd0;
         ang  = source_angle(longint'($signed(r.src_x)), longint'($signed(r.src_y)));
         prod = 64'(ang) * 64'(NUM_BINS);
         idx  = prod[63:32];
         sum  = 32'(level_map[idx]) + ((32'(gain) * 32'(r.energy)) >> 8);
         if (sum > 32'(ceiling)) sum = 32'(ceiling);
         level_map[idx] = sum[7:0];
      end else begin
         idx = 32'(r.read_bin) % NUM_BINS;
         sum = 32'(level_map[idx]);
      end
      if (ceiling == 8'd0) begin
         b = 0;
      end else begin
         b = (sum * 32'(full_bright)) / 32'(ceiling);
         if (b > 255) b = 255;
         if (b < 32'(threshold)) b = 0;
      end
      o.bin        = idx[5:0];
      o.level      = sum[7:0];
      o.brightness = b[7:0];
      return o;
   endfunction

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (level_map[i]) level_map[i] = 8'd0;
         gain        = RST_INCREMENT;
         ceiling     = RST_MAX_LEVEL;
         decay       = RST_DECAY_STEP;
         threshold   = RST_MIN_THRESHOLD;
         full_bright = RST_MAX_BRIGHTNESS;
         expected_rsp.delete();
         fail_count  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INCREMENT:      gain        = csr_data;
               CSR_MAX_LEVEL:      ceiling     = csr_data;
               CSR_DECAY_STEP:     decay       = csr_data;
               CSR_MIN_THRESHOLD:  threshold   = csr_data;
               CSR_MAX_BRIGHTNESS: full_bright = csr_data;
               default: ;
            endcase
         end
         // a response always belongs to an earlier request: pop before push
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: response with nothing pending: expected none, actual %0d/%0d/%0d",
                           $time, rsp_payload.bin, rsp_payload.level, rsp_payload.brightness);
            end else begin
               want = expected_rsp.pop_front();
               check_field("bin", want.bin, rsp_payload.bin);
               check_field("level", want.level, rsp_payload.level);
               check_field("brightness", want.brightness, rsp_payload.brightness);
            end
         end
         if (req_valid && req_ready) expected_rsp.push_back(apply_request(req_payload));
      end
      outstanding <= expected_rsp.size();
      mismatches  <= fail_count;
   end

endmodule

/* dv/direction_energy_map_tb.sv */
// Testbench top for direction_energy_map: clock, reset, request and csr stimulus,
// response back-pressure, watchdog and verdict. Depends on dem_pkg and dem_checker.
module direction_energy_map_tb;
   import dem_pkg::*;

   localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 120;   // beyond the longest observation latency
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_ITEMS   = 205;
   localparam int NUM_REGS      = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;  // decodes to no register

   localparam logic [CSR_INDEX_W-1:0] REG_INDEX [NUM_REGS] = '{
      CSR_INCREMENT, CSR_MAX_LEVEL, CSR_DECAY_STEP, CSR_MIN_THRESHOLD, CSR_MAX_BRIGHTNESS
   };

   // Fixed settings for the first phases: full gain and ceiling with no decay,
   // a ceiling dropped under the stored levels, a zero ceiling, full decay, and
   // all ones but for a zero brightness. Later phases draw random settings.
   localparam logic [7:0] FIXED_CFG [5][NUM_REGS] = '{
      '{8'd255, 8'd255, 8'd0,   8'd0,   8'd255},
      '{8'd100, 8'd40,  8'd0,   8'd200, 8'd255},
      '{8'd0,   8'd0,   8'd2,   8'd0,   8'd255},
      '{8'd20,  8'd200, 8'd255, 8'd16,  8'd50},
      '{8'd1,   8'd1,   8'd1,   8'd1,   8'd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_data;

   int unsigned outstanding;
   int unsigned mismatches;

   int send_idle_pct;
   int recv_idle_pct;
   logic hold_go, hold_done;
   int   hold_left;
   int   quiet_cycles;
   int   observe_count, read_count, setting_count;

   direction_energy_map uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   dem_checker map_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: drop ready at random, or hold it low for one long stretch
   // once the stimulus asks, so the block backs up and stalls requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("** direction_energy_map: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type observe(input int x, input int y, input int e);
      req_type r;
      r          = '0;
      r.mode     = MODE_OBSERVE;
      r.src_x    = x[15:0];
      r.src_y    = y[15:0];
      r.energy   = e[8:0];
      r.read_bin = 6'(e);
      return r;
   endfunction

   function automatic req_type read_of(input int b);
      req_type r;
      r          = '0;
      r.mode     = MODE_READ;
      r.src_x    = 16'($urandom());
      r.src_y    = 16'($urandom());
      r.energy   = 9'($urandom());
      r.read_bin = b[5:0];
      return r;
   endfunction

   // one coordinate inside the Q1.14 unit range
   function automatic logic [15:0] unit_coord();
      int v;
      v = int'($urandom_range(32768)) - 16384;
      return v[15:0];
   endfunction

   function automatic logic [15:0] tiny_coord();
      int v;
      v = int'($urandom_range(4)) - 2;
      return v[15:0];
   endfunction

   // Mostly in-range directions; some full-width noise, exact axes, x at -32768
   // and near-origin vectors where the angle special-cases and CORDIC meet.
   function automatic req_type pick_request();
      req_type     r;
      int unsigned sel;
      r.mode     = ($urandom_range(99) < 60) ? MODE_OBSERVE : MODE_READ;
      r.read_bin = 6'($urandom());
      r.energy   = ($urandom_range(99) < 80) ? 9'($urandom_range(256)) : 9'($urandom());
      sel = $urandom_range(99);
      if (sel < 70) begin
         r.src_x = unit_coord();
         r.src_y = unit_coord();
      end else if (sel < 85) begin
         r.src_x = 16'($urandom());
         r.src_y = 16'($urandom());
      end else begin
         case ($urandom_range(3))
            0: begin
               r.src_x = unit_coord();
               r.src_y = '0;
            end
            1: begin
               r.src_x = '0;
               r.src_y = unit_coord();
            end
            2: begin
               r.src_x = tiny_coord();
               r.src_y = tiny_coord();
            end
            default: begin
               r.src_x = 16'h8000;
               r.src_y = 16'($urandom());
            end
         endcase
      end
      return r;
   endfunction

   // Offer one request, idling first at the sender's rate, and hold it until taken.
   task automatic send_req(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (r.mode == MODE_OBSERVE) observe_count++;
      else read_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      req_type    directed_q [$];
      logic [7:0] cfg [NUM_REGS];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      hold_go       = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 77;
      observe_count = 0;
      read_count    = 0;
      setting_count = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under the reset settings: origin, the four exact
      // axes, corner extremes, zero and full-scale energy, both sides of the
      // half-turn and wrap-around boundaries, and reads across the modulo.
      directed_q.push_back(read_of(0));
      directed_q.push_back(observe(0, 0, 256));
      directed_q.push_back(observe(16384, 0, 256));
      directed_q.push_back(observe(-16384, 0, 256));
      directed_q.push_back(observe(0, 16384, 256));
      directed_q.push_back(observe(0, -16384, 256));
      directed_q.push_back(observe(-32768, -32768, 511));
      directed_q.push_back(observe(32767, 32767, 511));
      directed_q.push_back(observe(-32768, 32767, 511));
      directed_q.push_back(observe(16384, 16384, 0));
      directed_q.push_back(observe(-1, 1, 1));
      directed_q.push_back(observe(1, -1, 255));
      directed_q.push_back(observe(-16384, 1, 256));
      directed_q.push_back(observe(-16384, -1, 256));
      directed_q.push_back(observe(16384, -1, 256));
      directed_q.push_back(read_of(35));
      directed_q.push_back(read_of(36));
      directed_q.push_back(read_of(63));
      directed_q.push_back(read_of(9));
      directed_q.push_back(read_of(18));
      directed_q.push_back(read_of(27));
      foreach (directed_q[i]) send_req(directed_q[i]);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         // sender light and receiver heavy, then swapped, then no idling
         if (p < 3) begin
            send_idle_pct = 11;
            recv_idle_pct = 77;
         end else if (p < 6) begin
            send_idle_pct = 77;
            recv_idle_pct = 11;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         // reprogram only while idle: the previous phase has fully drained
         for (int k = 0; k < NUM_REGS; k++)
            cfg[k] = (p < 5) ? FIXED_CFG[p][k] : 8'($urandom());
         if (p == 1) write_csr(CSR_SPARE, 8'($urandom()));
         for (int k = 0; k < NUM_REGS; k++) write_csr(REG_INDEX[k], cfg[k]);
         csr_valid <= 1'b0;
         setting_count++;

         // first unthrottled phase: hold responses off while requests keep coming
         if (p == 6) hold_go <= 1'b1;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // once, let the block run dry in the middle of a phase
            if (p == 4 && n == PHASE_ITEMS / 2) drain();
            send_req(pick_request());
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d observations and %0d reads over %0d register settings,",
               observe_count, read_count, setting_count);
      $display("with idle mixes on both sides, a long response hold-off; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("** direction_energy_map: PASSED **");
      end else begin
         $display("** direction_energy_map: FAILED **");
      end
      $finish;
   end

endmodule
